FILE: rtl/core/suc_pkg.sv
// Package for the sorted unique code set: sizes, operation codes and transaction types.
`default_nettype none
package suc_pkg;

  localparam int Capacity = 16;
  localparam int HeldW    = $clog2(Capacity + 1);
  localparam int IdxW     = $clog2(Capacity);
  localparam int CodeW    = 32;
  localparam int IndexW   = 8;
  localparam int CountW   = 5;
  localparam int CmpW     = (HeldW > IndexW) ? HeldW : IndexW;

  typedef enum logic [1:0] {
    FnInsert = 2'd0,
    FnRemove = 2'd1,
    FnClear  = 2'd2,
    FnRead   = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [CodeW-1:0]   code;
    logic [IndexW-1:0]  index;
  } suc_in_t;

  typedef struct packed {
    logic [CodeW-1:0]   read_code;
    logic [CountW-1:0]  count;
    logic               dropped;
  } suc_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/suc_array.sv
// Register array of sorted codes with parallel compare, shift-insert and shift-remove.
`default_nettype none
module suc_array
  import suc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire suc_in_t  item_i,
  output suc_out_t      result_o
);

  logic [CodeW-1:0] entries_q [Capacity];
  logic [CodeW-1:0] entries_d [Capacity];
  logic [HeldW-1:0] held_q, held_d;

  logic [Capacity-1:0] valid, lt, eq, ins_pos;
  logic                found, full, do_ins, do_rem;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      valid[i] = HeldW'(i) < held_q;
      lt[i]    = valid[i] && (entries_q[i] < item_i.code);
      eq[i]    = valid[i] && (entries_q[i] == item_i.code);
    end
    // lt is a prefix, so the insert slot is where it ends
    ins_pos[0] = !lt[0];
    for (int i = 1; i < Capacity; i++) begin
      ins_pos[i] = !lt[i] && lt[i-1];
    end
  end

  assign found  = |eq;
  assign full   = held_q == HeldW'(Capacity);
  assign do_ins = (item_i.func == FnInsert) && !found && !full;
  assign do_rem = (item_i.func == FnRemove) && found;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins && !lt[i]) begin
        if (ins_pos[i]) begin
          entries_d[i] = item_i.code;
        end else if (i > 0) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem && !lt[i] && (i < Capacity - 1)) begin
        entries_d[i] = entries_q[(i < Capacity - 1) ? i + 1 : i];
      end
    end

    held_d = held_q;
    unique case (item_i.func)
      FnInsert: if (do_ins) held_d = held_q + HeldW'(1);
      FnRemove: if (do_rem) held_d = held_q - HeldW'(1);
      FnClear:  held_d = '0;
      FnRead:   held_d = held_q;
      default:  held_d = held_q;
    endcase
  end

  always_comb begin
    result_o = '0;
    if ((item_i.func == FnRead) && (CmpW'(item_i.index) < CmpW'(held_q))) begin
      result_o.read_code = entries_q[item_i.index[IdxW-1:0]];
    end
    result_o.count   = CountW'(held_d);
    result_o.dropped = (item_i.func == FnInsert) && !found && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (step_i) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && (do_ins || do_rem)) begin
      entries_q <= entries_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_unique_code_set_top.sv
// Top level of the sorted unique code set: input register, code array and result register.
//
// Usage: send one transaction per operation on the input channel (in_valid_i /
// in_ready_o / in_data_i): insert a code, remove a code, clear the set, or read
// the entry at an ascending index. Each transaction returns exactly one result
// on the output channel (out_valid_o / out_ready_i / out_data_o) with the read
// value (0 unless a read hits a held entry), the count after the operation and
// the dropped flag for an insert of a new code into a full set.
// An accepted transaction sits in the input register while the array compare
// and shift runs, and the result register loads when the transaction advances.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset empties the set and clears the valid flags of both pipeline registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o drops only when both are occupied.
`default_nettype none
module sorted_unique_code_set_top
  import suc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire suc_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output suc_out_t     out_data_o
);

  logic     in_valid_q;
  suc_in_t  in_q;
  logic     out_valid_q;
  suc_out_t out_q;
  suc_out_t result;
  logic     advance;

  // advance the held transaction when the result slot is free or being taken
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  suc_array u_array (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the sorted unique code set: directed and random transactions.
`timescale 1ns / 1ps
module testbench;
  import suc_pkg::*;

  localparam int RandomOps  = 630;
  localparam int CycleLimit = 200000;
  localparam int PoolSize   = 20;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  suc_in_t  in_data = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  suc_out_t out_data_o;

  sorted_unique_code_set_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the set, ascending in slots 0..held_n-1
  logic [CodeW-1:0] set_codes [Capacity];
  int               held_n = 0;

  suc_in_t  pending_ops [$];
  suc_out_t expected_results [$];
  suc_out_t want;
  int       total_ops = 0;
  int       ops_sent = 0;
  int       results_seen = 0;
  int       drops_seen = 0;
  int       read_hits = 0;
  int       fail_cnt = 0;
  int       cycle_cnt = 0;
  logic [CodeW-1:0] code_pool [PoolSize];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // First slot whose code is not below c
  function automatic int lower_slot(logic [CodeW-1:0] c);
    int i;
    i = 0;
    while (i < held_n && set_codes[i] < c) i++;
    return i;
  endfunction

  function automatic suc_out_t apply_op(suc_in_t t);
    suc_out_t r;
    int slot;
    int k;
    r = '0;
    case (t.func)
      FnInsert: begin
        slot = lower_slot(t.code);
        if (!(slot < held_n && set_codes[slot] == t.code)) begin
          if (held_n >= Capacity) begin
            r.dropped = 1'b1;
          end else begin
            for (k = held_n; k > slot; k--) set_codes[k] = set_codes[k-1];
            set_codes[slot] = t.code;
            held_n++;
          end
        end
      end
      FnRemove: begin
        slot = lower_slot(t.code);
        if (slot < held_n && set_codes[slot] == t.code) begin
          for (k = slot; k + 1 < held_n; k++) set_codes[k] = set_codes[k+1];
          held_n--;
        end
      end
      FnClear: held_n = 0;
      default: begin
        if (int'(t.index) < held_n) r.read_code = set_codes[t.index[IdxW-1:0]];
      end
    endcase
    r.count = CountW'(held_n);
    return r;
  endfunction

  // Phases: none, sender idle, receiver stall, both
  function automatic int send_idle_pct(int sent);
    case ((sent * 4) / ((total_ops > 0) ? total_ops : 1))
      1: return 46;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int sent);
    case ((sent * 4) / ((total_ops > 0) ? total_ops : 1))
      2: return 46;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  function automatic suc_in_t make_op(func_e f, logic [CodeW-1:0] c, logic [IndexW-1:0] idx);
    suc_in_t t;
    t.func  = f;
    t.code  = c;
    t.index = idx;
    return t;
  endfunction

  // Append one transaction to the pending queue
  task automatic add_op(func_e f, logic [CodeW-1:0] c, logic [IndexW-1:0] idx);
    pending_ops = {pending_ops, make_op(f, c, idx)};
  endtask

  // Driver: predict on acceptance, then present the next pending transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready_o) begin
      if (in_valid) begin
        expected_results = {expected_results, apply_op(in_data)};
        ops_sent++;
      end
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct(ops_sent)) begin
        in_valid <= 1'b1;
        in_data  <= pending_ops.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no transaction pending: %p", out_data_o);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.read_code !== want.read_code) begin
            $error("read_code: expected %h, actual %h", want.read_code, out_data_o.read_code);
            fail_cnt++;
          end
          if (out_data_o.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_data_o.count);
            fail_cnt++;
          end
          if (out_data_o.dropped !== want.dropped) begin
            $error("dropped: expected %b, actual %b", want.dropped, out_data_o.dropped);
            fail_cnt++;
          end
          if (want.dropped) drops_seen++;
          if (want.read_code != '0) read_hits++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct(ops_sent));
    end
  end

  initial begin
    int r;
    func_e f;
    logic [CodeW-1:0] c;
    logic [IndexW-1:0] idx;

    // Directed: empty reads, extreme codes, duplicates, misses, clear
    add_op(FnRead,   32'h0,        8'd0);
    add_op(FnRead,   32'hFFFF_FFFF, 8'd255);
    add_op(FnRemove, 32'h1234_5678, 8'd0);
    add_op(FnInsert, 32'hFFFF_FFFF, 8'hFF);
    add_op(FnInsert, 32'h0,        8'd0);
    add_op(FnInsert, 32'h0,        8'd0);
    add_op(FnInsert, 32'h8000_0000, 8'd0);
    add_op(FnInsert, 32'h7FFF_FFFF, 8'd0);
    add_op(FnRead,   32'h0,        8'd0);
    add_op(FnRead,   32'h0,        8'd1);
    add_op(FnRead,   32'h0,        8'd2);
    add_op(FnRead,   32'h0,        8'd3);
    add_op(FnRead,   32'h0,        8'd4);
    add_op(FnRemove, 32'h5555_5555, 8'd0);
    add_op(FnRemove, 32'h8000_0000, 8'd0);
    add_op(FnRead,   32'h0,        8'd2);
    add_op(FnRemove, 32'hFFFF_FFFF, 8'd0);
    add_op(FnRead,   32'h0,        8'd255);
    add_op(FnClear,  32'hAAAA_AAAA, 8'hAA);
    add_op(FnRead,   32'h0,        8'd0);
    add_op(FnRemove, 32'h0,        8'd0);

    // Random: mostly codes from a small pool so the set fills, hits and drops
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 120 == 0) begin
        for (int i = 0; i < PoolSize; i++) code_pool[i] = $urandom;
        code_pool[0] = 32'h0;
        code_pool[1] = 32'hFFFF_FFFF;
        code_pool[2] = $urandom_range(7);
      end
      r = $urandom_range(99);
      if (r < 48)      f = FnInsert;
      else if (r < 68) f = FnRemove;
      else if (r < 97) f = FnRead;
      else             f = FnClear;
      c   = ($urandom_range(99) < 85) ? code_pool[$urandom_range(PoolSize-1)] : $urandom;
      idx = ($urandom_range(99) < 80) ? IndexW'($urandom_range(Capacity + 1))
                                      : IndexW'($urandom_range(255));
      add_op(f, c, idx);
    end
    total_ops = pending_ops.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d transactions, %0d results checked", ops_sent, results_seen);
    $display("%0d inserts dropped on a full set, %0d reads returned a held code",
             drops_seen, read_hits);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
